// File: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and constants for the bitmap pool allocator
// Field widths, command and register codes, sequencer states and the result
// record of the free-bit finder.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_POOLS_DEF = 16;
  localparam int MAX_NODES_DEF = 1024;

  // Word size of the used-bit memory.
  localparam int WORD_W     = 64;
  localparam int BIT_IDX_W  = 6;

  // Port field widths.
  localparam int CMD_W      = 2;
  localparam int POOL_IDX_W = 4;
  localparam int NODE_IDX_W = 10;
  localparam int COUNT_W    = 15;

  // Configuration registers.
  localparam int SIZE_W     = 11;
  localparam int PCOUNT_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [SIZE_W-1:0]   POOL_SIZE_RST  = 11'd1024;
  localparam logic [PCOUNT_W-1:0] POOL_COUNT_RST = 5'd16;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT = 2'd1;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POOL,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_REL_RD,
    ST_REL_CHK
  } state_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] bit_idx;
  } find_t;

endpackage

// File: hw/rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/bpa_bit_find.sv
// ----------------------------------------------------------------------------
// bpa_bit_find: lowest free node in one bitmap word
// Masks off nodes at or above the pool size and returns the lowest clear bit.
// ----------------------------------------------------------------------------
module bpa_bit_find
  import bpa_pkg::*;
#(
  parameter int WOFF_W = 4
) (
  input  logic [WORD_W-1:0] word,
  input  logic [WOFF_W-1:0] word_off,
  input  logic [SIZE_W-1:0] size,
  output find_t             result
);

  localparam int HI_W = SIZE_W - BIT_IDX_W;
  localparam int CMP_W = (WOFF_W > HI_W) ? WOFF_W : HI_W;

  logic [CMP_W-1:0]  off_ext;
  logic [CMP_W-1:0]  size_hi;
  logic              word_full;
  logic              word_part;
  logic [WORD_W-1:0] avail;

  assign off_ext   = CMP_W'(word_off);
  assign size_hi   = CMP_W'(size[SIZE_W-1:BIT_IDX_W]);
  // A word wholly below the pool size is fully usable; the word holding the
  // pool size is usable only below its low bits.
  assign word_full = off_ext < size_hi;
  assign word_part = off_ext == size_hi;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      avail[b] = ~word[b] &
                 (word_full | (word_part & (BIT_IDX_W'(b) < size[BIT_IDX_W-1:0])));
    end
  end

  always_comb begin
    result = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        result.found   = 1'b1;
        result.bit_idx = BIT_IDX_W'(b);
      end
    end
  end

endmodule

// File: hw/rtl/bitmap_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_pool_allocator_unit: first-fit node allocator over a chain of pools
// Each pool keeps one used bit per node in a shared bitmap RAM plus a free
// counter; the block also keeps the total free count.
//
// Commands arrive as transactions on the in_ channel (allocate, release,
// check) and each produces one transaction on the out_ channel. Check
// completes in the cycle it is accepted. Release reads the bitmap word,
// then tests the bit and writes it back, or completes at once when it is
// out of range. Allocate walks the pool counters one per cycle, then reads
// and tests the bitmap words of the chosen pool in turn until a free bit is
// found. One command is worked on at a time; a new one is taken once the
// sequencer is idle and the result register is empty or being drained
// that cycle.
//
// After reset, and after every write to the pool size or pool count
// register, the bitmap RAM is cleared one word per cycle and in_ready
// stays low meanwhile. A stalled out_ready holds the result and blocks the
// next command.
// ----------------------------------------------------------------------------
module bitmap_pool_allocator_unit
  import bpa_pkg::*;
#(
  parameter int MAX_POOLS = MAX_POOLS_DEF,
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [POOL_IDX_W-1:0] in_pool_index,
  input  logic [NODE_IDX_W-1:0] in_node_index,
  input  logic [COUNT_W-1:0]    in_required,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_status,
  output logic [POOL_IDX_W-1:0] out_granted_pool,
  output logic [NODE_IDX_W-1:0] out_granted_node,
  output logic                  out_enough,
  output logic [COUNT_W-1:0]    out_available,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WPP        = (MAX_NODES + WORD_W - 1) / WORD_W;
  localparam int WORD_TOTAL = MAX_POOLS * WPP;
  localparam int AW         = (WORD_TOTAL > 1) ? $clog2(WORD_TOTAL) : 1;
  localparam int WOFF_W     = (WPP > 1) ? $clog2(WPP) : 1;
  localparam int PW         = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int PCW        = $clog2(MAX_POOLS + 1);

  // Configuration and derived limits.
  logic [SIZE_W-1:0]   pool_size_r;
  logic [PCOUNT_W-1:0] pool_count_r;
  logic [SIZE_W-1:0]   size_eff;
  logic [PCOUNT_W-1:0] pools_eff;
  logic                cfg_wr;

  // Sequencer.
  state_t              state_r, state_nxt;
  logic [PCW-1:0]      ptr_r, ptr_nxt;
  logic [WOFF_W-1:0]   woff_r, woff_nxt;
  logic [SIZE_W-1:0]   node_r, node_nxt;
  logic [AW-1:0]       clr_idx_r;

  // Counters.
  logic [SIZE_W-1:0]   free_cnt_r [MAX_POOLS];
  logic [COUNT_W-1:0]  total_r, total_nxt;
  logic [SIZE_W-1:0]   cur_cnt;
  logic                cnt_inc;
  logic                cnt_dec;

  // Bitmap RAM.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;
  find_t               find;

  // Result register.
  logic                  res_load;
  logic                  res_status;
  logic [POOL_IDX_W-1:0] res_pool;
  logic [NODE_IDX_W-1:0] res_node;
  logic                  res_enough;
  logic                  out_valid_r;
  logic                  out_status_r;
  logic [POOL_IDX_W-1:0] out_pool_r;
  logic [NODE_IDX_W-1:0] out_node_r;
  logic                  out_enough_r;
  logic [COUNT_W-1:0]    out_avail_r;

  logic                  in_acc;
  logic                  in_range;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  assign size_eff  = (32'(pool_size_r) > MAX_NODES) ? SIZE_W'(MAX_NODES) : pool_size_r;
  assign pools_eff = (32'(pool_count_r) > MAX_POOLS) ? PCOUNT_W'(MAX_POOLS) : pool_count_r;

  assign in_ready = (state_r == ST_IDLE) & (~out_valid_r | out_ready);
  assign in_acc   = in_valid & in_ready;
  assign in_range = (32'(in_pool_index) < 32'(pools_eff)) &
                    (32'(in_node_index) < 32'(size_eff));

  assign cur_cnt   = free_cnt_r[ptr_r[PW-1:0]];
  assign ram_raddr = AW'(ptr_r[PW-1:0] * WPP) + AW'(woff_r);

  bpa_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (WORD_TOTAL)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  bpa_bit_find #(
    .WOFF_W (WOFF_W)
  ) u_find (
    .word     (ram_rdata),
    .word_off (woff_r),
    .size     (size_eff),
    .result   (find)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      pool_size_r  <= POOL_SIZE_RST;
      pool_count_r <= POOL_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      // A register write restarts initialization with the new value.
      if (cfg_wr && (cfg_index == REG_POOL_SIZE || cfg_index == REG_POOL_COUNT)) begin
        if (cfg_index == REG_POOL_SIZE) begin
          pool_size_r <= cfg_data;
        end else begin
          pool_count_r <= cfg_data[PCOUNT_W-1:0];
        end
        state_r   <= ST_CLEAR;
        clr_idx_r <= '0;
      end else begin
        state_r <= state_nxt;
        if (state_r == ST_CLEAR) begin
          clr_idx_r <= clr_idx_r + 1'b1;
        end
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    woff_r  <= woff_nxt;
    node_r  <= node_nxt;
    total_r <= total_nxt;
    if (state_r == ST_CLEAR) begin
      for (int p = 0; p < MAX_POOLS; p++) begin
        free_cnt_r[p] <= (32'(p) < 32'(pools_eff)) ? size_eff : '0;
      end
    end else if (cnt_dec) begin
      free_cnt_r[ptr_r[PW-1:0]] <= cur_cnt - 1'b1;
    end else if (cnt_inc) begin
      free_cnt_r[ptr_r[PW-1:0]] <= cur_cnt + 1'b1;
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_pool_r   <= res_pool;
      out_node_r   <= res_node;
      out_enough_r <= res_enough;
      out_avail_r  <= total_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    woff_nxt   = woff_r;
    node_nxt   = node_r;
    total_nxt  = total_r;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ram_raddr;
    ram_wdata  = ram_rdata;
    res_load   = 1'b0;
    res_status = 1'b1;
    res_pool   = '0;
    res_node   = '0;
    res_enough = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = '0;
        total_nxt = COUNT_W'(size_eff) * COUNT_W'(pools_eff);
        if (clr_idx_r == AW'(WORD_TOTAL - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          case (in_command)
            CMD_ALLOC: begin
              ptr_nxt   = '0;
              state_nxt = ST_POOL;
            end
            CMD_RELEASE: begin
              if (in_range) begin
                ptr_nxt   = PCW'(in_pool_index);
                node_nxt  = SIZE_W'(in_node_index);
                woff_nxt  = WOFF_W'(in_node_index >> BIT_IDX_W);
                state_nxt = ST_REL_RD;
              end else begin
                res_load = 1'b1;
              end
            end
            CMD_CHECK: begin
              res_load   = 1'b1;
              res_status = 1'b0;
              res_enough = total_r >= in_required;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      ST_POOL: begin
        if (32'(ptr_r) >= 32'(pools_eff)) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (cur_cnt != '0) begin
          woff_nxt  = '0;
          state_nxt = ST_ALLOC_RD;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      ST_ALLOC_RD: begin
        state_nxt = ST_ALLOC_CHK;
      end

      ST_ALLOC_CHK: begin
        if (find.found) begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata | (WORD_W'(1) << find.bit_idx);
          cnt_dec    = 1'b1;
          total_nxt  = total_r - 1'b1;
          res_load   = 1'b1;
          res_status = 1'b0;
          res_pool   = POOL_IDX_W'(ptr_r);
          res_node   = NODE_IDX_W'({woff_r, find.bit_idx});
          state_nxt  = ST_IDLE;
        end else begin
          woff_nxt  = woff_r + 1'b1;
          state_nxt = ST_ALLOC_RD;
        end
      end

      ST_REL_RD: begin
        state_nxt = ST_REL_CHK;
      end

      ST_REL_CHK: begin
        res_load  = 1'b1;
        state_nxt = ST_IDLE;
        if (ram_rdata[node_r[BIT_IDX_W-1:0]]) begin
          ram_we     = 1'b1;
          ram_wdata  = ram_rdata & ~(WORD_W'(1) << node_r[BIT_IDX_W-1:0]);
          cnt_inc    = 1'b1;
          total_nxt  = total_r + 1'b1;
          res_status = 1'b0;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_pool = out_pool_r;
  assign out_granted_node = out_node_r;
  assign out_enough       = out_enough_r;
  assign out_available    = out_avail_r;

endmodule
